/* rtl/akm_pkg.sv */
`timescale 1ns / 1ps

package akm_pkg;

   localparam int CHANNELS        = 4;
   localparam int F_BITS          = 16;
   localparam int GUARD_BITS      = 4;
   localparam int P_BITS          = F_BITS + GUARD_BITS;
   // weights run from 0 to exactly 1.0, so they need one bit above the fraction
   localparam int W_BITS          = P_BITS + 1;
   localparam int CFG_BITS        = F_BITS + 1;
   localparam int BIAS_BITS       = 16;
   localparam int GAIN_FRAC       = 12;
   localparam int SEL_BITS        = 3;
   localparam int MAP_BITS        = 12;
   localparam int INDEX_BITS      = 3;
   localparam int LANE_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SQ_PROD_BITS    = 2 * W_BITS;
   localparam int BLEND_PROD_BITS = W_BITS + P_BITS;
   localparam int BIAS_PROD_BITS  = P_BITS + BIAS_BITS;

   localparam logic [F_BITS:0]   ONE_F = (F_BITS + 1)'(1) << F_BITS;
   localparam logic [W_BITS-1:0] ONE_P = W_BITS'(1) << P_BITS;

   localparam logic [INDEX_BITS-1:0] REG_EPSILON     = INDEX_BITS'(0);
   localparam logic [INDEX_BITS-1:0] REG_SMOOTHING   = INDEX_BITS'(1);
   localparam logic [INDEX_BITS-1:0] REG_FINE_STEP   = INDEX_BITS'(2);
   localparam logic [INDEX_BITS-1:0] REG_BIAS_DOWN   = INDEX_BITS'(3);
   localparam logic [INDEX_BITS-1:0] REG_BIAS_GAIN   = INDEX_BITS'(4);
   localparam logic [INDEX_BITS-1:0] REG_CHANNEL_MAP = INDEX_BITS'(5);

   localparam logic [SEL_BITS-1:0] SEL_ZERO = SEL_BITS'(CHANNELS);
   localparam logic [SEL_BITS-1:0] SEL_FULL = SEL_BITS'(CHANNELS + 1);

   typedef struct packed {
      logic load;     // capture the samples of a new item
      logic mul;      // form the two blend products
      logic sum;      // write the new smoothed value
      logic commit;   // copy smoothed into last accepted
      logic bias;     // form the bias product
   } lane_ctl_type;

endpackage

/* rtl/akm_max.sv */
`timescale 1ns / 1ps

module akm_max (
   input  logic [akm_pkg::P_BITS-1:0] vals [akm_pkg::CHANNELS],
   output logic [akm_pkg::P_BITS-1:0] max_val
);

   always_comb begin
      max_val = '0;
      for (int i = 0; i < akm_pkg::CHANNELS; i++) begin
         if (vals[i] > max_val) begin
            max_val = vals[i];
         end
      end
   end

endmodule

/* rtl/akm_lane.sv */
`timescale 1ns / 1ps

module akm_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  akm_pkg::lane_ctl_type              ctl,
   input  logic [akm_pkg::F_BITS-1:0]         knob,
   input  logic [akm_pkg::W_BITS-1:0]         op,
   input  logic [akm_pkg::BIAS_BITS-1:0]      bias_down,
   input  logic [akm_pkg::BIAS_BITS-1:0]      bias_gain,
   output logic [akm_pkg::P_BITS-1:0]         diff,
   output logic [akm_pkg::P_BITS-1:0]         move,
   output logic [akm_pkg::F_BITS:0]           biased
);

   localparam int P  = akm_pkg::P_BITS;
   localparam int BP = akm_pkg::BLEND_PROD_BITS;
   localparam int XP = akm_pkg::BIAS_PROD_BITS;

   logic [P-1:0]  sample_ff, sample_in;
   logic [P-1:0]  smoothed_ff, smoothed_in;
   logic [P-1:0]  last_ff, last_in;
   logic [BP-1:0] keep_prod_ff, keep_prod_in;
   logic [BP-1:0] hold_prod_ff, hold_prod_in;
   logic [XP-1:0] bias_prod_ff, bias_prod_in;

   logic [akm_pkg::W_BITS-1:0] keep;
   logic [BP-1:0]              blend_sum;
   logic [P-1:0]               down;
   logic [P-1:0]               scaled;

   assign sample_in = {knob, akm_pkg::GUARD_BITS'(0)};
   assign keep      = akm_pkg::ONE_P - op;

   assign diff = (sample_ff >= smoothed_ff) ? (sample_ff - smoothed_ff)
                                            : (smoothed_ff - sample_ff);
   assign move = (smoothed_ff >= last_ff) ? (smoothed_ff - last_ff)
                                          : (last_ff - smoothed_ff);

   assign keep_prod_in = BP'(keep) * BP'(sample_ff);
   assign hold_prod_in = BP'(op) * BP'(smoothed_ff);

   // weights add to one, so the sum stays below 2^(2P)
   assign blend_sum   = keep_prod_ff + hold_prod_ff;
   assign smoothed_in = blend_sum[2*P-1:P];
   assign last_in     = smoothed_ff;

   assign down = {bias_down, akm_pkg::GUARD_BITS'(0)};

   always_comb begin
      if (last_ff > down) begin
         bias_prod_in = XP'(last_ff - down) * XP'(bias_gain);
      end else begin
         bias_prod_in = '0;
      end
   end

   // drop gain and guard fraction bits, then clamp at 1.0
   assign scaled = bias_prod_ff[XP-1:akm_pkg::GAIN_FRAC + akm_pkg::GUARD_BITS];
   assign biased = (scaled > P'(akm_pkg::ONE_F)) ? akm_pkg::ONE_F
                                                 : scaled[akm_pkg::F_BITS:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff <= '0;
         last_ff     <= '0;
      end else begin
         if (ctl.sum) begin
            smoothed_ff <= smoothed_in;
         end
         if (ctl.commit) begin
            last_ff <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sample_ff <= sample_in;
      end
      if (ctl.mul) begin
         keep_prod_ff <= keep_prod_in;
         hold_prod_ff <= hold_prod_in;
      end
      if (ctl.bias) begin
         bias_prod_ff <= bias_prod_in;
      end
   end

endmodule

/* rtl/adaptive_knob_smoother.sv */
`timescale 1ns / 1ps

// adaptive knob smoother: takes one item of four Q0.16 knob samples, blends each into
// a smoothed value with a weight that drops as the largest knob jump grows, decides
// whether the new values count as a deliberate turn, and returns one result item
// carrying the accept and timer-restart flags and four bias-scaled, clamped, routed
// channels. a sequencer walks one item through nine dependent steps (max deviation,
// square, blend weight, blend products, smoothed write, max move, decision, bias
// product, routing) before req_ready rises again. four lanes work in parallel on
// the knobs, and the deviation and move maxima are merged across lanes. the result
// sits in an output register, so a new item is taken while the previous result
// waits; only the routing step waits for that register to free up. no clearing
// pass after reset.
// configuration must be written only while no item is in work.

module adaptive_knob_smoother (
   input  logic                               clock,
   input  logic                               reset,
   // input items
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [akm_pkg::F_BITS-1:0]         req_knob_0,
   input  logic [akm_pkg::F_BITS-1:0]         req_knob_1,
   input  logic [akm_pkg::F_BITS-1:0]         req_knob_2,
   input  logic [akm_pkg::F_BITS-1:0]         req_knob_3,
   input  logic                               req_force_req,
   input  logic                               req_control_lost,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_accepted,
   output logic                               rsp_restart_timer,
   output logic [akm_pkg::F_BITS:0]           rsp_channel_0,
   output logic [akm_pkg::F_BITS:0]           rsp_channel_1,
   output logic [akm_pkg::F_BITS:0]           rsp_channel_2,
   output logic [akm_pkg::F_BITS:0]           rsp_channel_3,
   // configuration writes
   input  logic                               csr_we,
   input  logic [akm_pkg::INDEX_BITS-1:0]     csr_index,
   input  logic [akm_pkg::CFG_BITS-1:0]       csr_wdata
);

   localparam int N = akm_pkg::CHANNELS;
   localparam int F = akm_pkg::F_BITS;
   localparam int P = akm_pkg::P_BITS;
   localparam int W = akm_pkg::W_BITS;
   localparam int G = akm_pkg::GUARD_BITS;

   // one-hot sequencer
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_MD     = 10'b00_0000_0010,
      ST_SQ     = 10'b00_0000_0100,
      ST_OP     = 10'b00_0000_1000,
      ST_MUL    = 10'b00_0001_0000,
      ST_SUM    = 10'b00_0010_0000,
      ST_MOVE   = 10'b00_0100_0000,
      ST_DECIDE = 10'b00_1000_0000,
      ST_BIAS   = 10'b01_0000_0000,
      ST_ROUTE  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [akm_pkg::CFG_BITS-1:0]  epsilon_ff, epsilon_in;
   logic [akm_pkg::CFG_BITS-1:0]  smoothing_ff, smoothing_in;
   logic [akm_pkg::CFG_BITS-1:0]  fine_step_ff, fine_step_in;
   logic [akm_pkg::BIAS_BITS-1:0] bias_down_ff, bias_down_in;
   logic [akm_pkg::BIAS_BITS-1:0] bias_gain_ff, bias_gain_in;
   logic [akm_pkg::MAP_BITS-1:0]  map_ff, map_in;

   // control state
   logic kic_ff, kic_in;
   logic rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic         force_ff, lost_ff;
   logic [P-1:0] md_ff;
   logic [F:0]   omc_ff, omc_in;
   logic [W-1:0] sq_ff, sq_in;
   logic [W-1:0] op_ff, op_in;
   logic [P-1:0] move_ff;
   logic         accept_ff, accept_in;
   logic         restart_ff, restart_in;

   // result register
   logic         rsp_accepted_ff, rsp_restart_ff;
   logic [F:0]   rsp_chan_ff [N];
   logic [F:0]   rsp_chan_in [N];

   logic [F-1:0] knob [N];
   logic [P-1:0] lane_diff [N];
   logic [P-1:0] lane_move [N];
   logic [F:0]   lane_biased [N];
   logic [P-1:0] md_max, move_max;

   akm_pkg::lane_ctl_type lane_ctl;

   logic                  take_item;
   logic                  slot_free;
   logic [F:0]            c_factor;
   logic [W-1:0]          om;
   logic [akm_pkg::SQ_PROD_BITS-1:0] sq_prod, op_prod;
   logic [W-1:0]          weight;
   logic                  kic_eff, big_move, fine;

   assign take_item = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   assign knob[0] = req_knob_0;
   assign knob[1] = req_knob_1;
   assign knob[2] = req_knob_2;
   assign knob[3] = req_knob_3;

   // lanes
   assign lane_ctl.load   = take_item;
   assign lane_ctl.mul    = (state_ff == ST_MUL);
   assign lane_ctl.sum    = (state_ff == ST_SUM);
   assign lane_ctl.commit = (state_ff == ST_DECIDE) && accept_in;
   assign lane_ctl.bias   = (state_ff == ST_BIAS);

   for (genvar i = 0; i < N; i++) begin : g_lane
      akm_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl),
         .knob      (knob[i]),
         .op        (op_ff),
         .bias_down (bias_down_ff),
         .bias_gain (bias_gain_ff),
         .diff      (lane_diff[i]),
         .move      (lane_move[i]),
         .biased    (lane_biased[i])
      );
   end

   // merge across lanes
   akm_max u_md_max (
      .vals    (lane_diff),
      .max_val (md_max)
   );

   akm_max u_move_max (
      .vals    (lane_move),
      .max_val (move_max)
   );

   // base factor, forced to one, otherwise saturated at one
   always_comb begin
      if (force_ff) begin
         c_factor = akm_pkg::ONE_F;
      end else if (smoothing_ff > akm_pkg::ONE_F) begin
         c_factor = akm_pkg::ONE_F;
      end else begin
         c_factor = smoothing_ff;
      end
   end
   assign omc_in = akm_pkg::ONE_F - c_factor;

   // (1 - md)^2, truncated
   assign om      = akm_pkg::ONE_P - W'(md_ff);
   assign sq_prod = akm_pkg::SQ_PROD_BITS'(om) * akm_pkg::SQ_PROD_BITS'(om);
   assign sq_in   = sq_prod[P +: W];

   // op = (1 - c) * (1 - md)^2
   assign weight  = {omc_ff, G'(0)};
   assign op_prod = akm_pkg::SQ_PROD_BITS'(weight) * akm_pkg::SQ_PROD_BITS'(sq_ff);
   assign op_in   = op_prod[P +: W];

   // acceptance decision, control loss applies first
   assign kic_eff    = kic_ff && !lost_ff;
   assign big_move   = W'(move_ff) > {epsilon_ff, G'(0)};
   assign fine       = kic_eff && (W'(move_ff) > {fine_step_ff, G'(0)});
   assign accept_in  = big_move || fine || force_ff;
   assign restart_in = big_move || force_ff;

   always_comb begin
      kic_in = kic_ff;
      if (state_ff == ST_DECIDE) begin
         kic_in = accept_in ? 1'b1 : kic_eff;
      end
   end

   // channel routing
   always_comb begin
      logic [akm_pkg::SEL_BITS-1:0] sel;
      for (int i = 0; i < N; i++) begin
         sel = map_ff[akm_pkg::SEL_BITS*i +: akm_pkg::SEL_BITS];
         if (sel < akm_pkg::SEL_ZERO) begin
            rsp_chan_in[i] = lane_biased[sel[akm_pkg::LANE_BITS-1:0]];
         end else if (sel == akm_pkg::SEL_FULL) begin
            rsp_chan_in[i] = akm_pkg::ONE_F;
         end else begin
            rsp_chan_in[i] = '0;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (take_item) state_in = ST_MD;
         ST_MD:     state_in = ST_SQ;
         ST_SQ:     state_in = ST_OP;
         ST_OP:     state_in = ST_MUL;
         ST_MUL:    state_in = ST_SUM;
         ST_SUM:    state_in = ST_MOVE;
         ST_MOVE:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_BIAS;
         ST_BIAS:   state_in = ST_ROUTE;
         ST_ROUTE:  if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_ROUTE) && slot_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // register writes
   always_comb begin
      epsilon_in   = epsilon_ff;
      smoothing_in = smoothing_ff;
      fine_step_in = fine_step_ff;
      bias_down_in = bias_down_ff;
      bias_gain_in = bias_gain_ff;
      map_in       = map_ff;
      if (csr_we) begin
         unique case (csr_index)
            akm_pkg::REG_EPSILON:     epsilon_in   = csr_wdata;
            akm_pkg::REG_SMOOTHING:   smoothing_in = csr_wdata;
            akm_pkg::REG_FINE_STEP:   fine_step_in = csr_wdata;
            akm_pkg::REG_BIAS_DOWN:   bias_down_in = csr_wdata[akm_pkg::BIAS_BITS-1:0];
            akm_pkg::REG_BIAS_GAIN:   bias_gain_in = csr_wdata[akm_pkg::BIAS_BITS-1:0];
            akm_pkg::REG_CHANNEL_MAP: map_in       = csr_wdata[akm_pkg::MAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kic_ff       <= 1'b0;
         epsilon_ff   <= akm_pkg::CFG_BITS'(0);
         smoothing_ff <= akm_pkg::CFG_BITS'(6554);
         fine_step_ff <= akm_pkg::CFG_BITS'(23);
         bias_down_ff <= akm_pkg::BIAS_BITS'(0);
         bias_gain_ff <= akm_pkg::BIAS_BITS'(4096);
         map_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kic_ff       <= kic_in;
         epsilon_ff   <= epsilon_in;
         smoothing_ff <= smoothing_in;
         fine_step_ff <= fine_step_in;
         bias_down_ff <= bias_down_in;
         bias_gain_ff <= bias_gain_in;
         map_ff       <= map_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (take_item) begin
         force_ff <= req_force_req;
         lost_ff  <= req_control_lost;
      end
      if (state_ff == ST_MD) begin
         md_ff  <= md_max;
         omc_ff <= omc_in;
      end
      if (state_ff == ST_SQ) begin
         sq_ff <= sq_in;
      end
      if (state_ff == ST_OP) begin
         op_ff <= op_in;
      end
      if (state_ff == ST_MOVE) begin
         move_ff <= move_max;
      end
      if (state_ff == ST_DECIDE) begin
         accept_ff  <= accept_in;
         restart_ff <= restart_in;
      end
      if ((state_ff == ST_ROUTE) && slot_free) begin
         rsp_accepted_ff <= accept_ff;
         rsp_restart_ff  <= restart_ff;
         for (int i = 0; i < N; i++) begin
            rsp_chan_ff[i] <= rsp_chan_in[i];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_restart_timer = rsp_restart_ff;
   assign rsp_channel_0     = rsp_chan_ff[0];
   assign rsp_channel_1     = rsp_chan_ff[1];
   assign rsp_channel_2     = rsp_chan_ff[2];
   assign rsp_channel_3     = rsp_chan_ff[3];

endmodule

/* rtl/akm_checker.sv */
`timescale 1ns / 1ps

module akm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_accepted,
   input logic                               rsp_restart_timer,
   input logic [akm_pkg::F_BITS:0]           rsp_channel_0,
   input logic [akm_pkg::F_BITS:0]           rsp_channel_1,
   input logic [akm_pkg::F_BITS:0]           rsp_channel_2,
   input logic [akm_pkg::F_BITS:0]           rsp_channel_3
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one item at a time in the sequencer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken while previous item still in work");

   // a timer restart only comes with an accepted update
   a_restart_implies_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_restart_timer) |-> rsp_accepted)
      else $error("restart without acceptance");

   // channels never exceed full scale
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_channel_0 <= akm_pkg::ONE_F) && (rsp_channel_1 <= akm_pkg::ONE_F)
                 && (rsp_channel_2 <= akm_pkg::ONE_F) && (rsp_channel_3 <= akm_pkg::ONE_F))
      else $error("channel above full scale");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind adaptive_knob_smoother akm_checker u_akm_checker (.*);
